// ===== hw/rtl/llpm_pkg.sv =====
package llpm_pkg;

  // Pool geometry
  localparam int POOL_DEPTH = 64;
  localparam int KEY_BITS   = 64;
  localparam int ADDR_W     = $clog2(POOL_DEPTH);

  // Fixed field widths
  localparam int PTR_W = 7;   // entry pointer incl. null marker
  localparam int IDX_W = 6;   // reported entry index
  localparam int CNT_W = 7;   // live count, walk steps
  localparam int KEY_W = 64;  // key port width

  localparam logic [PTR_W-1:0] NIL = '1;

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Access request from sequencer to the key and link memories
  typedef struct packed {
    addr_t raddr;
    addr_t waddr;
    logic  key_we;
    logic  next_we;
    key_t  wkey;
    ptr_t  wnext;
  } mem_req_t;

endpackage

// ===== hw/rtl/llpm_ram.sv =====
module llpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/llpm_seq.sv =====
module llpm_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_op,
  input  logic [llpm_pkg::KEY_W-1:0] in_key,
  input  logic                    in_use_hint,
  input  logic [llpm_pkg::IDX_W-1:0] in_hint_index,
  output llpm_pkg::mem_req_t      mem_req,
  input  llpm_pkg::key_t          key_rd,
  input  llpm_pkg::ptr_t          next_rd,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [llpm_pkg::IDX_W-1:0] out_entry_index,
  output logic                    out_has_prev,
  output logic [llpm_pkg::IDX_W-1:0] out_prev_entry,
  output logic [llpm_pkg::KEY_W-1:0] out_key_out,
  output logic [llpm_pkg::CNT_W-1:0] out_live_count,
  output logic                    out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_POP,
    S_WALK,
    S_RM_LINK,
    S_RM_FREE
  } state_t;

  state_t                      state_r, state_nxt;
  llpm_pkg::op_t               op_r, op_nxt;
  llpm_pkg::key_t              key_r, key_nxt;
  logic                        hint_r, hint_nxt;
  llpm_pkg::ptr_t              hidx_r, hidx_nxt;
  llpm_pkg::ptr_t              used_head_r, used_head_nxt;
  llpm_pkg::ptr_t              free_head_r, free_head_nxt;
  llpm_pkg::ptr_t              fresh_r, fresh_nxt;
  logic [llpm_pkg::CNT_W-1:0]  count_r, count_nxt;
  llpm_pkg::ptr_t              cur_r, cur_nxt;
  llpm_pkg::ptr_t              prev_r, prev_nxt;
  logic [llpm_pkg::CNT_W-1:0]  steps_r, steps_nxt;
  llpm_pkg::ptr_t              rm_idx_r, rm_idx_nxt;
  llpm_pkg::ptr_t              rm_prev_r, rm_prev_nxt;
  llpm_pkg::key_t              rm_key_r, rm_key_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;
  logic [llpm_pkg::IDX_W-1:0]  out_index_r, out_index_nxt;
  logic                        out_has_prev_r, out_has_prev_nxt;
  logic [llpm_pkg::IDX_W-1:0]  out_prev_r, out_prev_nxt;
  logic [llpm_pkg::KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [llpm_pkg::CNT_W-1:0]  out_count_r, out_count_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        add_go;
  llpm_pkg::ptr_t              add_idx;
  logic                        hit;
  logic                        more;
  logic                        prev_ok;
  logic                        rm_prev_ok;

  function automatic logic is_live(llpm_pkg::ptr_t p);
    return p < llpm_pkg::PTR_W'(llpm_pkg::POOL_DEPTH);
  endfunction

  function automatic llpm_pkg::addr_t to_addr(llpm_pkg::ptr_t p);
    return p[llpm_pkg::ADDR_W-1:0];
  endfunction

  assign busy = (state_r != S_IDLE);

  // Walk compare terms
  assign hit = (op_r == llpm_pkg::OP_REMOVE && hint_r) ? (cur_r == hidx_r)
                                                        : (key_rd == key_r);
  assign more = is_live(next_rd) &&
                ((steps_r + llpm_pkg::CNT_W'(1)) < llpm_pkg::CNT_W'(llpm_pkg::POOL_DEPTH));
  assign prev_ok    = is_live(prev_r);
  assign rm_prev_ok = is_live(rm_prev_r);

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    hint_nxt      = hint_r;
    hidx_nxt      = hidx_r;
    used_head_nxt = used_head_r;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    rm_idx_nxt    = rm_idx_r;
    rm_prev_nxt   = rm_prev_r;
    rm_key_nxt    = rm_key_r;

    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_index_nxt    = out_index_r;
    out_has_prev_nxt = out_has_prev_r;
    out_prev_nxt     = out_prev_r;
    out_key_nxt      = out_key_r;
    out_count_nxt    = out_count_r;
    out_last_nxt     = out_last_r;

    mem_req = '0;
    add_go  = 1'b0;
    add_idx = free_head_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = llpm_pkg::op_t'(in_op);
          key_nxt   = in_key[llpm_pkg::KEY_BITS-1:0];
          hint_nxt  = in_use_hint;
          hidx_nxt  = llpm_pkg::PTR_W'(in_hint_index);
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (op_r == llpm_pkg::OP_ADD) begin
          if (is_live(free_head_r)) begin
            // fetch link of the free head before popping it
            mem_req.raddr = to_addr(free_head_r);
            state_nxt     = S_ADD_POP;
          end else if (fresh_r < llpm_pkg::PTR_W'(llpm_pkg::POOL_DEPTH)) begin
            add_go    = 1'b1;
            add_idx   = fresh_r;
            fresh_nxt = fresh_r + llpm_pkg::PTR_W'(1);
          end else begin
            out_valid_nxt    = 1'b1;
            out_status_nxt   = llpm_pkg::ST_FULL;
            out_index_nxt    = '0;
            out_has_prev_nxt = 1'b0;
            out_prev_nxt     = '0;
            out_key_nxt      = '0;
            out_last_nxt     = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else if (!is_live(used_head_r) ||
                     (op_r == llpm_pkg::OP_REMOVE && hint_r && !is_live(hidx_r))) begin
          // empty list or out-of-range hint
          out_valid_nxt    = 1'b1;
          out_status_nxt   = llpm_pkg::ST_MISS;
          out_index_nxt    = '0;
          out_has_prev_nxt = 1'b0;
          out_prev_nxt     = '0;
          out_key_nxt      = '0;
          out_last_nxt     = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          mem_req.raddr = to_addr(used_head_r);
          cur_nxt       = used_head_r;
          prev_nxt      = llpm_pkg::NIL;
          steps_nxt     = '0;
          state_nxt     = S_WALK;
        end
      end

      S_ADD_POP: begin
        add_go        = 1'b1;
        add_idx       = free_head_r;
        free_head_nxt = next_rd;
      end

      S_WALK: begin
        // key and link of cur_r are on the read port this cycle
        if (op_r == llpm_pkg::OP_LIST) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = llpm_pkg::ST_OK;
          out_index_nxt    = llpm_pkg::IDX_W'(cur_r);
          out_has_prev_nxt = prev_ok;
          out_prev_nxt     = prev_ok ? llpm_pkg::IDX_W'(prev_r) : '0;
          out_key_nxt      = llpm_pkg::KEY_W'(key_rd);
          out_last_nxt     = !more;
        end

        if (op_r == llpm_pkg::OP_FIND && hit) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = llpm_pkg::ST_OK;
          out_index_nxt    = llpm_pkg::IDX_W'(cur_r);
          out_has_prev_nxt = prev_ok;
          out_prev_nxt     = prev_ok ? llpm_pkg::IDX_W'(prev_r) : '0;
          out_key_nxt      = llpm_pkg::KEY_W'(key_rd);
          out_last_nxt     = 1'b1;
          state_nxt        = S_IDLE;
        end else if (op_r == llpm_pkg::OP_REMOVE && hit && hint_r && is_live(next_rd)) begin
          // unlink the successor of the hint entry
          rm_idx_nxt    = next_rd;
          rm_prev_nxt   = cur_r;
          mem_req.raddr = to_addr(next_rd);
          state_nxt     = S_RM_LINK;
        end else if (op_r == llpm_pkg::OP_REMOVE && hit && !hint_r) begin
          rm_idx_nxt    = cur_r;
          rm_prev_nxt   = prev_r;
          mem_req.raddr = to_addr(cur_r);
          state_nxt     = S_RM_LINK;
        end else if (more && !(op_r == llpm_pkg::OP_REMOVE && hit)) begin
          // advance one entry, read issued on the fresh link
          prev_nxt      = cur_r;
          cur_nxt       = next_rd;
          steps_nxt     = steps_r + llpm_pkg::CNT_W'(1);
          mem_req.raddr = to_addr(next_rd);
        end else begin
          if (op_r != llpm_pkg::OP_LIST) begin
            out_valid_nxt    = 1'b1;
            out_status_nxt   = llpm_pkg::ST_MISS;
            out_index_nxt    = '0;
            out_has_prev_nxt = 1'b0;
            out_prev_nxt     = '0;
            out_key_nxt      = '0;
            out_last_nxt     = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_RM_LINK: begin
        // bypass the removed entry
        rm_key_nxt = key_rd;
        if (rm_prev_ok) begin
          mem_req.next_we = 1'b1;
          mem_req.waddr   = to_addr(rm_prev_r);
          mem_req.wnext   = next_rd;
        end else begin
          used_head_nxt = next_rd;
        end
        state_nxt = S_RM_FREE;
      end

      S_RM_FREE: begin
        // push the slot onto the free list
        mem_req.next_we  = 1'b1;
        mem_req.waddr    = to_addr(rm_idx_r);
        mem_req.wnext    = free_head_r;
        free_head_nxt    = rm_idx_r;
        if (count_r != '0) begin
          count_nxt = count_r - llpm_pkg::CNT_W'(1);
        end
        out_valid_nxt    = 1'b1;
        out_status_nxt   = llpm_pkg::ST_OK;
        out_index_nxt    = llpm_pkg::IDX_W'(rm_idx_r);
        out_has_prev_nxt = rm_prev_ok;
        out_prev_nxt     = rm_prev_ok ? llpm_pkg::IDX_W'(rm_prev_r) : '0;
        out_key_nxt      = llpm_pkg::KEY_W'(rm_key_r);
        out_last_nxt     = 1'b1;
        state_nxt        = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Add: write the entry and link it in at the head
    if (add_go) begin
      mem_req.key_we   = 1'b1;
      mem_req.next_we  = 1'b1;
      mem_req.waddr    = to_addr(add_idx);
      mem_req.wkey     = key_r;
      mem_req.wnext    = used_head_r;
      used_head_nxt    = add_idx;
      count_nxt        = count_r + llpm_pkg::CNT_W'(1);
      out_valid_nxt    = 1'b1;
      out_status_nxt   = llpm_pkg::ST_OK;
      out_index_nxt    = llpm_pkg::IDX_W'(add_idx);
      out_has_prev_nxt = 1'b0;
      out_prev_nxt     = '0;
      out_key_nxt      = llpm_pkg::KEY_W'(key_r);
      out_last_nxt     = 1'b1;
      state_nxt        = S_IDLE;
    end

    if (out_valid_nxt) begin
      out_count_nxt = count_nxt;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_head_r <= llpm_pkg::NIL;
      free_head_r <= llpm_pkg::NIL;
      fresh_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_head_r <= used_head_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r           <= op_nxt;
    key_r          <= key_nxt;
    hint_r         <= hint_nxt;
    hidx_r         <= hidx_nxt;
    cur_r          <= cur_nxt;
    prev_r         <= prev_nxt;
    steps_r        <= steps_nxt;
    rm_idx_r       <= rm_idx_nxt;
    rm_prev_r      <= rm_prev_nxt;
    rm_key_r       <= rm_key_nxt;
    out_status_r   <= out_status_nxt;
    out_index_r    <= out_index_nxt;
    out_has_prev_r <= out_has_prev_nxt;
    out_prev_r     <= out_prev_nxt;
    out_key_r      <= out_key_nxt;
    out_count_r    <= out_count_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_index_r;
  assign out_has_prev    = out_has_prev_r;
  assign out_prev_entry  = out_prev_r;
  assign out_key_out     = out_key_r;
  assign out_live_count  = out_count_r;
  assign out_last        = out_last_r;

`ifndef SYNTH
  // list results come back to back until the last one
  a_list_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |=> out_valid_r)
    else $error("list burst broken before last result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= llpm_pkg::CNT_W'(llpm_pkg::POOL_DEPTH))
    else $error("live count above pool depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> steps_r < llpm_pkg::CNT_W'(llpm_pkg::POOL_DEPTH))
    else $error("walk ran past pool depth");

  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == llpm_pkg::ST_FULL |->
      !is_live(free_head_r) && fresh_r == llpm_pkg::PTR_W'(llpm_pkg::POOL_DEPTH))
    else $error("pool full reported with a slot available");
`endif

endmodule

// ===== hw/rtl/linked_list_pool_manager.sv =====
// Add: result follows S_DISPATCH, or S_DISPATCH and S_ADD_POP when reusing a freed slot.
// Find/remove: after S_DISPATCH, S_WALK visits one entry per cycle on the link memory
// read port, at most POOL_DEPTH entries; a removal hit adds S_RM_LINK and S_RM_FREE.
// List all: first result after S_DISPATCH and S_WALK, then one per cycle.
// Results are never stalled; a new request is taken only once busy has gone low.
// rst_n (synchronous, active low) empties both lists; memories are not cleared.
module linked_list_pool_manager (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_op,
  input  logic [llpm_pkg::KEY_W-1:0] in_key,
  input  logic                       in_use_hint,
  input  logic [llpm_pkg::IDX_W-1:0] in_hint_index,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [llpm_pkg::IDX_W-1:0] out_entry_index,
  output logic                       out_has_prev,
  output logic [llpm_pkg::IDX_W-1:0] out_prev_entry,
  output logic [llpm_pkg::KEY_W-1:0] out_key_out,
  output logic [llpm_pkg::CNT_W-1:0] out_live_count,
  output logic                       out_last
);

  llpm_pkg::mem_req_t mem_req;
  llpm_pkg::key_t     key_rd;
  llpm_pkg::ptr_t     next_rd;

  // Entry key store
  llpm_ram #(
    .WIDTH (llpm_pkg::KEY_BITS),
    .DEPTH (llpm_pkg::POOL_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (mem_req.key_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wkey),
    .raddr (mem_req.raddr),
    .rdata (key_rd)
  );

  // Entry link store
  llpm_ram #(
    .WIDTH (llpm_pkg::PTR_W),
    .DEPTH (llpm_pkg::POOL_DEPTH)
  ) u_next_ram (
    .clk   (clk),
    .we    (mem_req.next_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wnext),
    .raddr (mem_req.raddr),
    .rdata (next_rd)
  );

  // Request sequencer
  llpm_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_use_hint     (in_use_hint),
    .in_hint_index   (in_hint_index),
    .mem_req         (mem_req),
    .key_rd          (key_rd),
    .next_rd         (next_rd),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_has_prev    (out_has_prev),
    .out_prev_entry  (out_prev_entry),
    .out_key_out     (out_key_out),
    .out_live_count  (out_live_count),
    .out_last        (out_last)
  );

endmodule

// ===== tb/tb_linked_list_pool_manager.sv =====
module tb_linked_list_pool_manager;
  import llpm_pkg::*;

  // One request on the command port
  typedef struct {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic             use_hint;
    logic [IDX_W-1:0] hint_idx;
  } pool_req_t;

  // One result as the block reports it
  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] idx;
    logic             has_prev;
    logic [IDX_W-1:0] prev_idx;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic             is_last;
  } pool_result_t;

  localparam int KEY_SET_N = 24;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_op = OP_ADD;
  logic [KEY_W-1:0] in_key = '0;
  logic             in_use_hint = 1'b0;
  logic [IDX_W-1:0] in_hint_index = '0;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_entry_index;
  logic             out_has_prev;
  logic [IDX_W-1:0] out_prev_entry;
  logic [KEY_W-1:0] out_key_out;
  logic [CNT_W-1:0] out_live_count;
  logic             out_last;

  linked_list_pool_manager u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_use_hint     (in_use_hint),
    .in_hint_index   (in_hint_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_has_prev    (out_has_prev),
    .out_prev_entry  (out_prev_entry),
    .out_key_out     (out_key_out),
    .out_live_count  (out_live_count),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pool_req_t    queued_requests[$];
  pool_result_t pending_results[$];
  logic [KEY_W-1:0] key_set [KEY_SET_N];

  int unsigned total_reqs = 0;
  int unsigned accepted_reqs = 0;
  int unsigned checked_results = 0;
  int unsigned full_seen = 0;
  int unsigned miss_seen = 0;
  int unsigned op_seen [4] = '{0, 0, 0, 0};
  int unsigned err_cnt = 0;

  // Shadow of the pool: keys, links, list heads and slot bookkeeping
  logic [KEY_W-1:0] key_store [POOL_DEPTH];
  ptr_t             link_store [POOL_DEPTH];
  ptr_t             used_top = NIL;
  ptr_t             free_top = NIL;
  int unsigned      fresh_next = 0;
  int unsigned      live_cnt = 0;

  function automatic void push_result(status_t st, logic [IDX_W-1:0] idx, logic hp,
                                      logic [IDX_W-1:0] pidx, logic [KEY_W-1:0] key,
                                      logic is_last);
    pool_result_t r;
    r.status   = st;
    r.idx      = idx;
    r.has_prev = hp;
    r.prev_idx = pidx;
    r.key      = key;
    r.count    = CNT_W'(live_cnt);
    r.is_last  = is_last;
    if (st == ST_FULL) full_seen++;
    if (st == ST_MISS) miss_seen++;
    pending_results.push_back(r);
  endfunction

  // Walk the used list for a key match, or for a given entry index
  function automatic bit walk_used(input bit by_key, input logic [KEY_W-1:0] value,
                                   output ptr_t hit_idx, output ptr_t hit_prev);
    ptr_t p;
    ptr_t c;
    int   steps;
    p = NIL;
    c = used_top;
    hit_idx = NIL;
    hit_prev = NIL;
    for (steps = 0; steps < POOL_DEPTH && c < POOL_DEPTH; steps++) begin
      if (by_key ? (key_store[c] == value) : (KEY_W'(c) == value)) begin
        hit_idx = c;
        hit_prev = p;
        return 1'b1;
      end
      p = c;
      c = link_store[c];
    end
    return 1'b0;
  endfunction

  // Update the shadow pool for one accepted request and queue its results
  function automatic void apply_pool_request(pool_req_t rq);
    ptr_t idx;
    ptr_t prv;
    ptr_t hp;
    ptr_t p;
    ptr_t c;
    ptr_t n;
    bit   ok;
    int   k;
    op_seen[rq.op]++;
    case (rq.op)
      OP_ADD: begin
        ok = 1'b1;
        if (free_top < POOL_DEPTH) begin
          idx = free_top;
          free_top = link_store[idx];
        end else if (fresh_next < POOL_DEPTH) begin
          idx = ptr_t'(fresh_next);
          fresh_next++;
        end else begin
          ok = 1'b0;
        end
        if (!ok) begin
          push_result(ST_FULL, '0, 1'b0, '0, '0, 1'b1);
        end else begin
          key_store[idx] = rq.key;
          link_store[idx] = used_top;
          used_top = idx;
          live_cnt++;
          push_result(ST_OK, idx[IDX_W-1:0], 1'b0, '0, rq.key, 1'b1);
        end
      end
      OP_FIND: begin
        if (walk_used(1'b1, rq.key, idx, prv))
          push_result(ST_OK, idx[IDX_W-1:0], prv < POOL_DEPTH,
                      (prv < POOL_DEPTH) ? prv[IDX_W-1:0] : '0, key_store[idx], 1'b1);
        else
          push_result(ST_MISS, '0, 1'b0, '0, '0, 1'b1);
      end
      OP_REMOVE: begin
        // hinted: the hint must be live and have a successor
        if (rq.use_hint) begin
          ok = walk_used(1'b0, KEY_W'(rq.hint_idx), prv, hp);
          if (ok) begin
            idx = link_store[prv];
            ok = idx < POOL_DEPTH;
          end
        end else begin
          ok = walk_used(1'b1, rq.key, idx, prv);
        end
        if (!ok) begin
          push_result(ST_MISS, '0, 1'b0, '0, '0, 1'b1);
        end else begin
          if (prv < POOL_DEPTH) link_store[prv] = link_store[idx];
          else used_top = link_store[idx];
          link_store[idx] = free_top;
          free_top = idx;
          if (live_cnt > 0) live_cnt--;
          push_result(ST_OK, idx[IDX_W-1:0], prv < POOL_DEPTH,
                      (prv < POOL_DEPTH) ? prv[IDX_W-1:0] : '0, key_store[idx], 1'b1);
        end
      end
      default: begin
        k = 0;
        p = NIL;
        c = used_top;
        while (k < POOL_DEPTH && c < POOL_DEPTH) begin
          n = link_store[c];
          push_result(ST_OK, c[IDX_W-1:0], p < POOL_DEPTH,
                      (p < POOL_DEPTH) ? p[IDX_W-1:0] : '0, key_store[c],
                      (n >= POOL_DEPTH) || (k + 1 >= POOL_DEPTH));
          k++;
          p = c;
          c = n;
        end
        if (k == 0) push_result(ST_MISS, '0, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void queue_req(op_t op, logic [KEY_W-1:0] key, logic hint,
                                    logic [IDX_W-1:0] hidx);
    pool_req_t rq;
    rq.op = op;
    rq.key = key;
    rq.use_hint = hint;
    rq.hint_idx = hidx;
    queued_requests.push_back(rq);
    total_reqs++;
  endfunction

  // Random request; keys mostly from a small set so finds and removes hit
  function automatic void queue_random_req(int w_add, int w_find, int w_rem);
    int               roll;
    op_t              op;
    logic [KEY_W-1:0] key;
    roll = $urandom_range(0, 99);
    if (roll < w_add) op = OP_ADD;
    else if (roll < w_add + w_find) op = OP_FIND;
    else if (roll < w_add + w_find + w_rem) op = OP_REMOVE;
    else op = OP_LIST;
    if ($urandom_range(0, 4) == 0) key = {$urandom, $urandom};
    else key = key_set[$urandom_range(0, KEY_SET_N - 1)];
    queue_req(op, key, 1'(($urandom_range(0, 1))), IDX_W'($urandom_range(0, POOL_DEPTH - 1)));
  endfunction

  // Driver: bursts of requests with random gaps in between
  pool_req_t   drv_req;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_pool_request(drv_req);
        accepted_reqs++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          drv_req = queued_requests.pop_front();
          in_op         <= drv_req.op;
          in_key        <= drv_req.key;
          in_use_hint   <= drv_req.use_hint;
          in_hint_index <= drv_req.hint_idx;
          start         <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Monitor: every strobed result against the oldest expectation
  pool_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got entry %0d",
                 $time, out_entry_index);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("entry_index", want.idx, out_entry_index);
        check_field("has_prev", want.has_prev, out_has_prev);
        check_field("prev_entry", want.prev_idx, out_prev_entry);
        check_field("key_out", want.key, out_key_out);
        check_field("live_count", want.count, out_live_count);
        check_field("last", want.is_last, out_last);
        checked_results++;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    key_set[0] = '0;
    key_set[1] = '1;
    key_set[2] = {32'h8000_0000, 32'h0000_0001};
    for (int i = 3; i < KEY_SET_N; i++) key_set[i] = {$urandom, $urandom};

    // empty pool: every lookup misses, list reports empty
    queue_req(OP_LIST, '0, 1'b0, '0);
    queue_req(OP_FIND, '0, 1'b0, '0);
    queue_req(OP_REMOVE, 64'd5, 1'b0, '0);
    queue_req(OP_REMOVE, '0, 1'b1, 6'd0);
    // fresh slots 0..3, list becomes 3,2,1,0
    queue_req(OP_ADD, '0, 1'b0, '0);
    queue_req(OP_ADD, '1, 1'b1, '1);
    queue_req(OP_ADD, {16{4'hA}}, 1'b0, '0);
    queue_req(OP_ADD, {16{4'h5}}, 1'b0, '0);
    // tail, middle, head and a miss
    queue_req(OP_FIND, '0, 1'b0, '0);
    queue_req(OP_FIND, '1, 1'b0, '0);
    queue_req(OP_FIND, {16{4'h5}}, 1'b0, '0);
    queue_req(OP_FIND, 64'h1234, 1'b0, '0);
    queue_req(OP_LIST, '0, 1'b0, '0);
    // bad hints: tail has no successor, slot never used
    queue_req(OP_REMOVE, '0, 1'b1, 6'd0);
    queue_req(OP_REMOVE, '0, 1'b1, 6'd63);
    // hinted unlink after head, then keyed removal of head and tail
    queue_req(OP_REMOVE, '1, 1'b1, 6'd3);
    queue_req(OP_REMOVE, {16{4'h5}}, 1'b0, '0);
    queue_req(OP_REMOVE, '0, 1'b0, '0);
    // freed slots come back first; duplicate key found at head
    queue_req(OP_ADD, 64'h0123_4567_89ab_cdef, 1'b0, '0);
    queue_req(OP_ADD, '1, 1'b0, '0);
    queue_req(OP_FIND, '1, 1'b0, '0);
    queue_req(OP_REMOVE, '1, 1'b0, '0);
    queue_req(OP_LIST, '0, 1'b0, '0);
    // hint pointing into the free list
    queue_req(OP_REMOVE, '0, 1'b1, 6'd3);
    queue_req(OP_ADD, 64'h00ff_ff00_00ff_ff00, 1'b0, '0);

    // fill past full, churn, then drain
    for (int i = 0; i < 110; i++) queue_random_req(75, 12, 5);
    for (int i = 0; i < 150; i++) queue_random_req(35, 25, 32);
    for (int i = 0; i < 100; i++) queue_random_req(10, 15, 70);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_reqs < total_reqs) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d requests (add %0d, find %0d, remove %0d, list %0d); %0d results checked,",
             accepted_reqs, op_seen[OP_ADD], op_seen[OP_FIND], op_seen[OP_REMOVE],
             op_seen[OP_LIST], checked_results);
    $display("including %0d pool-full and %0d not-found results.", full_seen, miss_seen);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/llpm_pkg.sv
hw/rtl/llpm_ram.sv
hw/rtl/llpm_seq.sv
hw/rtl/linked_list_pool_manager.sv
tb/tb_linked_list_pool_manager.sv
